// File: src/rmot_pkg.sv
// Package for the rational mean of two block: field widths, stream packing
// constants and the sequencer's enum types. No dependencies.
package rmot_pkg;

  // Field widths
  localparam int NUM_W      = 64;
  localparam int DEN_W      = 31;
  localparam int MEAN_DEN_W = 63;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 128;

  // Shared adder width: a 64-bit word shifted once plus a carry bit
  localparam int ADD_W = NUM_W + 2;

  // Step counter for 31-step divide and multiply loops, gcd shift count
  localparam int CNT_W = $clog2(DEN_W);
  localparam int K_W   = $clog2(DEN_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DEN_W - 1);

  // Input field positions in in_tdata
  localparam int FN_LSB = 0;
  localparam int FD_LSB = FN_LSB + NUM_W;
  localparam int SN_LSB = FD_LSB + DEN_W;
  localparam int SD_LSB = SN_LSB + NUM_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV1,
    ST_DIV2,
    ST_PREP,
    ST_MUL,
    ST_FIX,
    ST_SUM
  } state_t;

  // Which product the multiply loop is working on
  typedef enum logic [1:0] {
    JOB_C1,
    JOB_C2,
    JOB_DEN
  } job_t;

endpackage

// File: src/rational_mean_of_two.sv
// Mean of two fractions (signed 64-bit numerators, 31-bit denominators).
// With equal denominators the sequencer goes straight to the final sum step;
// otherwise it runs a binary gcd, two 31-step restoring divisions,
// three 31-step shift-add multiplies and setup steps, all on one 66-bit adder.
// in_tready is high only when idle, so a new item waits until the last result is loaded;
// a held result stalls the final step. Reset (rst_n, sync, active low) idles, drops out_tvalid.
module rational_mean_of_two
  import rmot_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: first_num[63:0], first_den[94:64], second_num[158:95],
  //           second_den[189:159], zero pad[191:190]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: mean_num[63:0], mean_den[126:64], zero pad[127]
  // out_tuser: overflow[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  // Control state
  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Operands and working registers
  logic [NUM_W-1:0]      n1_r, n1_nxt, n2_r, n2_nxt;
  logic [DEN_W-1:0]      d1_r, d1_nxt, d2_r, d2_nxt;
  logic [DEN_W-1:0]      a_r, a_nxt, b_r, b_nxt, g_r, g_nxt;
  logic [K_W-1:0]        k_r, k_nxt;
  logic [DEN_W-1:0]      rem_r, rem_nxt, quo_r, quo_nxt;
  logic [DEN_W-1:0]      m1_r, m1_nxt, m2_r, m2_nxt, mf_r, mf_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [NUM_W-1:0]      acc_r, acc_nxt, mag_r, mag_nxt;
  logic                  big_r, big_nxt, neg_r, neg_nxt, ovf_r, ovf_nxt;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic                  user_r, user_nxt;

  // Shared adder/subtractor
  logic [ADD_W-1:0] add_a, add_b, add_sum;
  logic             add_sub;
  logic             gcd_ge;
  logic [DEN_W:0]   div_r2;

  assign gcd_ge  = (a_r >= b_r);
  assign div_r2  = {rem_r, quo_r[DEN_W-1]};
  assign add_sum = add_a + (add_b ^ {ADD_W{add_sub}}) + ADD_W'(add_sub);

  // Adder operand selection per sequencer step
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r)
      ST_GCD: begin
        add_a   = ADD_W'(gcd_ge ? a_r : b_r);
        add_b   = ADD_W'(gcd_ge ? b_r : a_r);
        add_sub = 1'b1;
      end
      ST_DIV1, ST_DIV2: begin
        add_a   = ADD_W'(div_r2);
        add_b   = ADD_W'(g_r);
        add_sub = 1'b1;
      end
      ST_PREP: begin
        add_b   = ADD_W'((job_r == JOB_C2) ? n2_r : n1_r);
        add_sub = 1'b1;
      end
      ST_MUL: begin
        add_a = {1'b0, acc_r, 1'b0};
        add_b = mf_r[DEN_W-1] ? ADD_W'(mag_r) : '0;
      end
      ST_FIX: begin
        add_b   = ADD_W'(acc_r);
        add_sub = 1'b1;
      end
      ST_SUM: begin
        add_a = ADD_W'(n1_r);
        add_b = ADD_W'(n2_r);
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  // Next state and datapath updates
  always_comb begin
    logic [NUM_W-1:0]      s;
    logic                  s_ovf;
    logic                  over;
    logic [NUM_W-1:0]      v;
    logic [MEAN_DEN_W-1:0] den_o;
    logic [NUM_W-1:0]      num_o;

    state_nxt     = state_r;
    job_nxt       = job_r;
    out_valid_nxt = out_valid_r;
    n1_nxt  = n1_r;  n2_nxt  = n2_r;
    d1_nxt  = d1_r;  d2_nxt  = d2_r;
    a_nxt   = a_r;   b_nxt   = b_r;   g_nxt = g_r;  k_nxt = k_r;
    rem_nxt = rem_r; quo_nxt = quo_r;
    m1_nxt  = m1_r;  m2_nxt  = m2_r;  mf_nxt = mf_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r; mag_nxt = mag_r;
    big_nxt = big_r; neg_nxt = neg_r; ovf_nxt = ovf_r;
    data_nxt = data_r;
    user_nxt = user_r;

    s     = add_sum[NUM_W-1:0];
    s_ovf = (n1_r[NUM_W-1] == n2_r[NUM_W-1]) && (s[NUM_W-1] != n1_r[NUM_W-1]);
    over  = neg_r ? (acc_r[NUM_W-1] & (|acc_r[NUM_W-2:0])) : acc_r[NUM_W-1];
    v     = (job_r == JOB_C2) ? n2_r : n1_r;
    num_o = s[0] ? s : {s[NUM_W-1], s[NUM_W-1:1]};
    den_o = s[0] ? {acc_r[MEAN_DEN_W-2:0], 1'b0} : acc_r[MEAN_DEN_W-1:0];

    in_tready = (state_r == ST_IDLE);

    // Output register drains independently of the sequencer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          n1_nxt  = in_tdata[FN_LSB +: NUM_W];
          d1_nxt  = in_tdata[FD_LSB +: DEN_W];
          n2_nxt  = in_tdata[SN_LSB +: NUM_W];
          d2_nxt  = in_tdata[SD_LSB +: DEN_W];
          a_nxt   = in_tdata[FD_LSB +: DEN_W];
          b_nxt   = in_tdata[SD_LSB +: DEN_W];
          k_nxt   = '0;
          ovf_nxt = 1'b0;
          acc_nxt = NUM_W'(in_tdata[FD_LSB +: DEN_W]);
          if (in_tdata[FD_LSB +: DEN_W] == in_tdata[SD_LSB +: DEN_W]) begin
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_GCD;
          end
        end
      end

      // Binary gcd, one step per cycle
      ST_GCD: begin
        if ((a_r == '0) || (b_r == '0)) begin
          g_nxt     = (a_r == '0) ? (b_r << k_r) : (a_r << k_r);
          quo_nxt   = d2_r;
          rem_nxt   = '0;
          cnt_nxt   = LAST_STEP;
          state_nxt = ST_DIV1;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + K_W'(1);
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else begin
          a_nxt = gcd_ge ? b_r : a_r;
          b_nxt = {1'b0, add_sum[DEN_W-1:1]};
        end
      end

      // Restoring division, one quotient bit per cycle
      ST_DIV1, ST_DIV2: begin
        if (!add_sum[ADD_W-1]) begin
          rem_nxt = add_sum[DEN_W-1:0];
        end else begin
          rem_nxt = div_r2[DEN_W-1:0];
        end
        quo_nxt = {quo_r[DEN_W-2:0], ~add_sum[ADD_W-1]};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          rem_nxt = '0;
          cnt_nxt = LAST_STEP;
          if (state_r == ST_DIV1) begin
            m1_nxt    = quo_nxt;
            quo_nxt   = d1_r;
            state_nxt = ST_DIV2;
          end else begin
            m2_nxt    = quo_nxt;
            job_nxt   = JOB_C1;
            state_nxt = ST_PREP;
          end
        end
      end

      // Take the magnitude of the numerator to be scaled
      ST_PREP: begin
        neg_nxt   = v[NUM_W-1];
        mag_nxt   = v[NUM_W-1] ? s : v;
        mf_nxt    = (job_r == JOB_C2) ? m2_r : m1_r;
        acc_nxt   = '0;
        big_nxt   = 1'b0;
        cnt_nxt   = LAST_STEP;
        state_nxt = ST_MUL;
      end

      // Shift-add multiply, factor MSB first; big marks a product past 64 bits
      ST_MUL: begin
        acc_nxt = add_sum[NUM_W-1:0];
        big_nxt = big_r | (add_sum[ADD_W-1:NUM_W] != '0);
        mf_nxt  = mf_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = (job_r == JOB_DEN) ? ST_SUM : ST_FIX;
        end
      end

      // Restore the sign, flag overflow, then queue the next product
      ST_FIX: begin
        ovf_nxt = ovf_r | big_r | over;
        if (job_r == JOB_C1) begin
          n1_nxt    = neg_r ? s : acc_r;
          job_nxt   = JOB_C2;
          state_nxt = ST_PREP;
        end else begin
          n2_nxt    = neg_r ? s : acc_r;
          job_nxt   = JOB_DEN;
          mag_nxt   = NUM_W'(d2_r);
          mf_nxt    = m2_r;
          neg_nxt   = 1'b0;
          acc_nxt   = '0;
          big_nxt   = 1'b0;
          cnt_nxt   = LAST_STEP;
          state_nxt = ST_MUL;
        end
      end

      // Final sum, halve or double, load the output register when free
      ST_SUM: begin
        if (!out_valid_r || out_tready) begin
          data_nxt      = {1'b0, den_o, num_o};
          user_nxt      = ovf_r | s_ovf;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= JOB_C1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n1_r   <= n1_nxt;   n2_r  <= n2_nxt;
    d1_r   <= d1_nxt;   d2_r  <= d2_nxt;
    a_r    <= a_nxt;    b_r   <= b_nxt;   g_r  <= g_nxt;  k_r <= k_nxt;
    rem_r  <= rem_nxt;  quo_r <= quo_nxt;
    m1_r   <= m1_nxt;   m2_r  <= m2_nxt;  mf_r <= mf_nxt;
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;  mag_r <= mag_nxt;
    big_r  <= big_nxt;  neg_r <= neg_nxt; ovf_r <= ovf_nxt;
    data_r <= data_nxt;
    user_r <= user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

// File: src/rmot_checker.sv
// Port-level checks for rational_mean_of_two, attached by bind.
// Depends on rmot_pkg and the top level's port names.
module rmot_checker
  import rmot_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // One item at a time: busy right after an input transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // A fresh result only comes out of a busy sequencer
  a_new_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without work");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind rational_mean_of_two rmot_checker u_rmot_checker (.*);
